FILE: sv/pph_pkg.sv
// Package for the PPM P6 header parser: types, character codes and limits.
package pph_pkg;

	typedef enum logic [2:0] {
		PH_P      = 3'd0,
		PH_SIX    = 3'd1,
		PH_NL     = 3'd2,
		PH_WIDTH  = 3'd3,
		PH_HEIGHT = 3'd4,
		PH_MAX    = 3'd5,
		PH_DRAIN  = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_MAGIC = 3'd1,
		ST_MISSING   = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_RANGE     = 3'd4
	} status_t;

	localparam int unsigned VAL_W = 31;
	localparam int unsigned MAX_W = 16;
	localparam int unsigned ACC_W = VAL_W + 4;

	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [ACC_W-1:0] VALUE_LIMIT = ACC_W'(32'h7FFF_FFFF);
	localparam logic [VAL_W-1:0] MAX_LIMIT   = VAL_W'(32'h0000_FFFF);

	typedef struct packed {
		phase_t             phase;
		logic [VAL_W-1:0]   acc;
		logic               digit;
		logic [VAL_W-1:0]   wd;
		logic [VAL_W-1:0]   ht;
	} parse_state_t;

	typedef struct packed {
		status_t            status;
		logic [VAL_W-1:0]   width;
		logic [VAL_W-1:0]   height;
		logic [MAX_W-1:0]   max_color;
	} result_t;

endpackage

FILE: sv/pph_if.sv
// Valid/ready channel interfaces for the byte stream and the header result.
interface pph_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pph_hdr_if;
	logic                         valid;
	logic                         ready;
	pph_pkg::status_t             status;
	logic [pph_pkg::VAL_W-1:0]    width;
	logic [pph_pkg::VAL_W-1:0]    height;
	logic [pph_pkg::MAX_W-1:0]    max_color;

	modport source (output valid, output status, output width, output height,
		output max_color, input ready);
	modport sink (input valid, input status, input width, input height,
		input max_color, output ready);
endinterface

FILE: sv/ppm_p6_header_parser.sv
// Top level of the PPM P6 header parser.
//  channel  dir  payload                                  beat
//  bytes    in   data_byte[7:0], last_byte                valid & ready
//  header   out  status[2:0], width, height, max_color    valid & ready
// One byte per cycle unless a held result stalls: input register, one parse
// step, result register. A byte sits in the input register during its step.
// Reset clears the parser to expect the magic line; no results pending.
// A held result stalls bytes only once the input register is also full.
module ppm_p6_header_parser (
	input  logic       clk,
	input  logic       arst_n,
	pph_byte_if.sink   bytes,
	pph_hdr_if.source  header
);

	logic                  s1_valid_q;
	logic [7:0]            data_s1;
	logic                  last_s1;
	pph_pkg::parse_state_t st_q;
	pph_pkg::parse_state_t st_nxt;
	logic                  step_emit;
	pph_pkg::result_t      step_res;
	logic                  out_free;
	logic                  proc;

	assign proc        = s1_valid_q && out_free;
	assign bytes.ready = !s1_valid_q || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (bytes.ready) begin
			s1_valid_q <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			data_s1 <= bytes.data_byte;
			last_s1 <= bytes.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: pph_pkg::PH_P, acc: '0, digit: 1'b0, wd: '0, ht: '0};
		end else if (proc) begin
			st_q <= st_nxt;
		end
	end

	pph_step u_step (
		.cur       (st_q),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.nxt       (st_nxt),
		.emit      (step_emit),
		.res       (step_res)
	);

	pph_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (proc && step_emit),
		.res    (step_res),
		.free   (out_free),
		.header (header)
	);

	a_drain_silent: assert property (@(posedge clk) disable iff (!arst_n)
		proc && (st_q.phase == pph_pkg::PH_DRAIN) |=> !$rose(header.valid))
		else $error("result from a drained byte");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !proc |=> s1_valid_q && $stable(data_s1) && $stable(last_s1))
		else $error("input register lost a stalled byte");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		proc && step_emit && last_s1 |=> st_q.phase == pph_pkg::PH_P)
		else $error("no restart after result on last byte");

	a_magic_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == pph_pkg::PH_P) |-> !st_q.digit && (st_q.acc == '0))
		else $error("stale number state at start of file");

endmodule

FILE: sv/pph_step.sv
// One parse step: next parser state and optional result for one byte.
module pph_step (
	input  pph_pkg::parse_state_t cur,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output pph_pkg::parse_state_t nxt,
	output logic                  emit,
	output pph_pkg::result_t      res
);

	pph_pkg::parse_state_t    adv;
	pph_pkg::status_t         st;
	logic                     judge;
	logic                     is_digit;
	logic                     is_space;
	logic [3:0]               dval;
	logic [pph_pkg::ACC_W-1:0] v;
	logic                     max_ok;

	assign is_digit = (data_byte >= pph_pkg::CH_ZERO) && (data_byte <= pph_pkg::CH_NINE);
	assign is_space = (data_byte == pph_pkg::CH_SPACE) || (data_byte == pph_pkg::CH_NL);
	assign dval     = 4'(data_byte - pph_pkg::CH_ZERO);
	assign v        = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0}
		+ pph_pkg::ACC_W'(dval);
	assign max_ok   = (adv.acc != '0) && (adv.acc <= pph_pkg::MAX_LIMIT);

	// decision
	always_comb begin
		adv   = cur;
		emit  = 1'b0;
		judge = 1'b0;
		st    = pph_pkg::ST_OK;
		unique case (cur.phase) inside
			pph_pkg::PH_P: begin
				if (data_byte != pph_pkg::CH_P) begin
					emit = 1'b1;
					st   = pph_pkg::ST_BAD_MAGIC;
				end else begin
					adv.phase = pph_pkg::PH_SIX;
				end
			end
			pph_pkg::PH_SIX: begin
				if (data_byte != pph_pkg::CH_SIX) begin
					emit = 1'b1;
					st   = pph_pkg::ST_BAD_MAGIC;
				end else begin
					adv.phase = pph_pkg::PH_NL;
				end
			end
			pph_pkg::PH_NL: begin
				if (data_byte != pph_pkg::CH_NL) begin
					emit = 1'b1;
					st   = pph_pkg::ST_BAD_MAGIC;
				end else begin
					adv       = '0;
					adv.phase = pph_pkg::PH_WIDTH;
				end
			end
			pph_pkg::PH_WIDTH, pph_pkg::PH_HEIGHT, pph_pkg::PH_MAX: begin
				if (cur.digit && is_digit) begin
					if (v > pph_pkg::VALUE_LIMIT) begin
						emit = 1'b1;
						st   = pph_pkg::ST_OVERFLOW;
					end else begin
						adv.acc = v[pph_pkg::VAL_W-1:0];
					end
				end else begin
					if (cur.digit) begin
						if (cur.phase == pph_pkg::PH_MAX) begin
							judge = 1'b1;
						end else begin
							if (cur.phase == pph_pkg::PH_WIDTH) begin
								adv.wd    = cur.acc;
								adv.phase = pph_pkg::PH_HEIGHT;
							end else begin
								adv.ht    = cur.acc;
								adv.phase = pph_pkg::PH_MAX;
							end
							adv.acc   = '0;
							adv.digit = 1'b0;
						end
					end
					if (!judge) begin
						if (is_digit) begin
							adv.acc   = pph_pkg::VAL_W'(dval);
							adv.digit = 1'b1;
						end else if (!is_space) begin
							emit = 1'b1;
							st   = pph_pkg::ST_MISSING;
						end
					end
				end
			end
			default: begin
				if (last_byte) begin
					adv       = '0;
					adv.phase = pph_pkg::PH_P;
				end
			end
		endcase

		// end of data inside the header
		if (!emit && !judge && last_byte && (cur.phase != pph_pkg::PH_DRAIN)
				&& (cur.phase <= pph_pkg::PH_MAX)) begin
			if (adv.phase < pph_pkg::PH_WIDTH) begin
				emit = 1'b1;
				st   = pph_pkg::ST_BAD_MAGIC;
			end else if ((adv.phase == pph_pkg::PH_MAX) && adv.digit) begin
				judge = 1'b1;
			end else begin
				emit = 1'b1;
				st   = pph_pkg::ST_MISSING;
			end
		end

		if (judge) begin
			emit = 1'b1;
			st   = max_ok ? pph_pkg::ST_OK : pph_pkg::ST_RANGE;
		end
	end

	// next state
	always_comb begin
		if (emit) begin
			nxt       = '0;
			nxt.phase = last_byte ? pph_pkg::PH_P : pph_pkg::PH_DRAIN;
		end else begin
			nxt = adv;
		end
	end

	// result
	always_comb begin
		res        = '0;
		res.status = st;
		if (st == pph_pkg::ST_OK) begin
			res.width     = adv.wd;
			res.height    = adv.ht;
			res.max_color = adv.acc[pph_pkg::MAX_W-1:0];
		end
	end

endmodule

FILE: sv/pph_out_stage.sv
// Result register driving the header channel.
module pph_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  pph_pkg::result_t  res,
	output logic              free,
	pph_hdr_if.source         header
);

	logic             valid_q;
	pph_pkg::result_t res_q;

	assign free = !valid_q || header.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign header.valid     = valid_q;
	assign header.status    = res_q.status;
	assign header.width     = res_q.width;
	assign header.height    = res_q.height;
	assign header.max_color = res_q.max_color;

endmodule
